>>> rtl/core/hpd_pkg.sv
// Shared types and constants of the preorder-tree Huffman decoder.
// Used by the serializer, the result buffer and the top level; depends on nothing.
package hpd_pkg;

	// Width of one decoded symbol and of the packed result data word.
	localparam int SYM_BITS = 8;
	localparam int TDATA_W  = 16;

	// Final status codes of a stream.
	typedef enum logic [2:0] {
		STS_OK         = 3'd0,
		STS_TRUNC      = 3'd1,
		STS_INCOMPLETE = 3'd2,
		STS_OVERFLOW   = 3'd3,
		STS_SINGLE     = 3'd4
	} status_t;

	// What a result beat carries.
	typedef enum logic {
		KIND_SYMBOL = 1'b0,
		KIND_REPORT = 1'b1
	} kind_t;

	// Requests from the decoder core into the result buffer.
	typedef struct packed {
		logic                sym_valid;
		logic [SYM_BITS-1:0] symbol;
		logic                close;
		logic                rpt_valid;
		status_t             rpt_status;
	} obuf_req_t;

	// Result buffer status back to the decoder core.
	typedef struct packed {
		logic ready;
		logic flushing;
	} obuf_sts_t;

endpackage

>>> rtl/core/hpd_ram.sv
// Simple dual-port memory with one write port and one registered read port.
// Holds the node store and the pending-node stack; no dependencies.
module hpd_ram #(
	parameter int AW = 9,
	parameter int DW = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	// Write and registered read; read data holds until the next read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/hpd_bit_serializer.sv
// Byte-to-bit shift register that presents compressed bits MSB first.
// Depends on hpd_pkg for the byte width.
module hpd_bit_serializer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic [hpd_pkg::SYM_BITS-1:0] load_byte,
	input  logic                        advance,
	output logic                        cur_bit,
	output logic                        last_bit
);
	import hpd_pkg::*;

	localparam int CW = $clog2(SYM_BITS);

	logic [SYM_BITS-1:0] shift_q;
	logic [CW-1:0]       left_q;

	assign cur_bit  = shift_q[SYM_BITS-1];
	assign last_bit = (left_q == '0);

	// Bit counter: counts the bits still to come after the current one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (load) begin
			left_q <= CW'(SYM_BITS - 1);
		end else if (advance && !last_bit) begin
			left_q <= left_q - CW'(1);
		end
	end

	// Data shift register, oldest bit at the top.
	always_ff @(posedge clk) begin
		if (load) begin
			shift_q <= load_byte;
		end else if (advance) begin
			shift_q <= {shift_q[SYM_BITS-2:0], 1'b0};
		end
	end

endmodule

>>> rtl/core/hpd_out_stage.sv
// Result buffer: holds back one decoded symbol so the last one of a byte can be
// marked, and drives the master stream from an output register. Uses hpd_pkg.
module hpd_out_stage (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hpd_pkg::obuf_req_t           req,
	output hpd_pkg::obuf_sts_t           sts,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [hpd_pkg::TDATA_W-1:0]  m_tdata,  // [7:0] symbol, [10:8] status, rest zero
	output logic                         m_tuser,  // kind: 0 symbol, 1 status report
	output logic                         m_tlast   // last result of the input beat
);
	import hpd_pkg::*;

	localparam int PadW = TDATA_W - SYM_BITS - 3;

	logic                out_valid_q;
	logic [TDATA_W-1:0]  out_data_q;
	kind_t               out_kind_q;
	logic                out_last_q;
	logic                pend_valid_q;
	logic [SYM_BITS-1:0] pend_sym_q;
	logic                flush_q;

	logic                out_free;
	logic                ld;
	logic                ld_last;
	kind_t               ld_kind;
	logic [SYM_BITS-1:0] ld_sym;
	status_t             ld_status;
	logic                pend_set;
	logic                pend_clr;

	assign out_free     = !out_valid_q || m_tready;
	assign sts.ready    = out_free && !flush_q;
	assign sts.flushing = flush_q;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	// Decide what goes into the output register this cycle.
	always_comb begin
		ld        = 1'b0;
		ld_last   = 1'b0;
		ld_kind   = KIND_SYMBOL;
		ld_sym    = pend_sym_q;
		ld_status = STS_OK;
		pend_set  = 1'b0;
		pend_clr  = 1'b0;
		priority if (flush_q) begin
			ld       = out_free;
			ld_last  = 1'b1;
			pend_clr = out_free;
		end else if (req.rpt_valid) begin
			ld        = 1'b1;
			ld_last   = 1'b1;
			ld_kind   = KIND_REPORT;
			ld_sym    = '0;
			ld_status = req.rpt_status;
		end else if (req.sym_valid) begin
			if (pend_valid_q) begin
				ld       = 1'b1;
				pend_set = 1'b1;
			end else if (req.close) begin
				ld      = 1'b1;
				ld_last = 1'b1;
				ld_sym  = req.symbol;
			end else begin
				pend_set = 1'b1;
			end
		end else if (req.close && pend_valid_q) begin
			ld       = 1'b1;
			ld_last  = 1'b1;
			pend_clr = 1'b1;
		end
	end

	// Output register, held symbol and flush flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
			out_kind_q   <= KIND_SYMBOL;
			out_last_q   <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_sym_q   <= '0;
			flush_q      <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (ld) begin
				out_valid_q <= 1'b1;
				out_data_q  <= {{PadW{1'b0}}, ld_status, ld_sym};
				out_kind_q  <= ld_kind;
				out_last_q  <= ld_last;
			end
			if (pend_set) begin
				pend_valid_q <= 1'b1;
				pend_sym_q   <= req.symbol;
				if (pend_valid_q && req.close) begin
					flush_q <= 1'b1;
				end
			end else if (pend_clr) begin
				pend_valid_q <= 1'b0;
				flush_q      <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/huffman_preorder_tree_decoder.sv
// Top level of the preorder-tree Huffman decoder: tree builder, tree walker,
// node store and pending stack. Uses hpd_pkg, hpd_ram, hpd_bit_serializer, hpd_out_stage.
//
// Usage. The slave stream carries one beat per compressed byte: s_tdata[7:0] is the
// byte, consumed most significant bit first, and s_tuser selects data (0) or end of
// input (1). The leading bits describe the code tree in preorder; the bits after it
// are decoded until cfg_data (the expected symbol count, written on the cfg channel
// while idle) symbols are out. Each decoded symbol leaves on the master stream with
// m_tuser 0; an end-of-input beat returns one status report with m_tuser 1 and then
// clears the decoder. m_tlast marks the last result caused by an input beat.
// Sequence. An accepted byte is loaded into the serializer and then shifted out one
// bit per cycle, pausing while the result buffer is not ready and in the link and
// fetch states. A leaf that closes a pending node adds a second node-store write in
// the link state; a decode bit taken while symbols are owed adds the fetch state for
// the registered read of the node store. A symbol is held back in the result buffer
// until the next symbol or the end of its byte, so the last one can be marked.
// Reset clears the control state; the stores need no clearing. While the output
// register is full and m_tready is low, bit processing pauses.
module huffman_preorder_tree_decoder #(
	parameter int MAX_LEAVES = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [31:0]                  cfg_data,   // expected_symbols
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,    // [7:0] data_byte
	input  logic                         s_tuser,    // command: 0 data, 1 end of input
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [hpd_pkg::TDATA_W-1:0]  m_tdata,    // [7:0] symbol, [10:8] status
	output logic                         m_tuser,    // kind
	output logic                         m_tlast     // last_in_run
);
	import hpd_pkg::*;

	localparam int NW        = $clog2(2 * MAX_LEAVES);
	localparam int EW        = (NW > SYM_BITS) ? NW : SYM_BITS;
	localparam int DW        = EW + 1;
	localparam int SW        = $clog2(MAX_LEAVES);
	localparam int NodeLimit = 2 * MAX_LEAVES - 1;
	localparam int LeafCW    = $clog2(SYM_BITS);

	typedef enum logic [1:0] {
		PH_FLAG,
		PH_LEAF,
		PH_DECODE,
		PH_HALT
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_BIT,
		S_LINK,
		S_FETCH,
		S_REPORT
	} state_t;

	state_t              state_q;
	phase_t              phase_q;
	logic [31:0]         expected_q;
	logic [31:0]         decoded_q;
	logic [NW-1:0]       nodes_used_q;
	logic [SW-1:0]       level_q;
	logic [LeafCW-1:0]   leaf_cnt_q;
	logic [SYM_BITS-1:0] leaf_shift_q;
	logic [NW-1:0]       walk_q;
	logic [NW-1:0]       cur_right_q;
	logic [NW-1:0]       root_right_q;
	logic [NW-1:0]       next_q;
	logic                close_q;
	status_t             err_q;

	logic                in_acc;
	logic                cur_bit;
	logic                last_bit;
	logic                bit_step;
	logic                fetch_step;
	logic                report_step;
	logic                ovf_nodes;
	logic                ovf_stack;
	logic                leaf_end;
	logic                owed;
	logic                root_leaf;
	logic                go_link;
	logic                go_fetch;
	logic [NW-1:0]       next_idx;
	logic [SYM_BITS-1:0] leaf_sym;
	status_t             rpt_status;

	logic                node_we;
	logic [NW-1:0]       node_waddr;
	logic [DW-1:0]       node_wdata;
	logic                node_re;
	logic [DW-1:0]       node_rdata;
	logic                stack_we;
	logic                stack_re;
	logic [SW-1:0]       stack_raddr;
	logic [NW-1:0]       stack_rdata;

	obuf_req_t           oreq;
	obuf_sts_t           osts;

	// Handshakes.
	assign cfg_ready   = 1'b1;
	assign s_tready    = (state_q == S_IDLE) && !osts.flushing;
	assign in_acc      = s_tvalid && s_tready;
	assign bit_step    = (state_q == S_BIT) && osts.ready;
	assign fetch_step  = (state_q == S_FETCH) && osts.ready;
	assign report_step = (state_q == S_REPORT) && osts.ready;

	// Per-bit conditions of the tree builder and walker.
	assign ovf_nodes   = (nodes_used_q >= NW'(NodeLimit));
	assign ovf_stack   = (level_q == SW'(MAX_LEAVES - 1));
	assign leaf_end    = (leaf_cnt_q == LeafCW'(SYM_BITS - 1));
	assign owed        = (decoded_q < expected_q);
	assign root_leaf   = (nodes_used_q == NW'(1));
	assign next_idx    = cur_bit ? cur_right_q : (walk_q + NW'(1));
	assign leaf_sym    = {leaf_shift_q[SYM_BITS-2:0], cur_bit};
	assign go_link     = bit_step && (phase_q == PH_LEAF) && leaf_end && (level_q != '0);
	assign go_fetch    = bit_step && (phase_q == PH_DECODE) && owed && !root_leaf;
	assign stack_raddr = level_q - SW'(1);

	// Status of the stream at end of input.
	always_comb begin
		priority if (err_q != STS_OK) begin
			rpt_status = err_q;
		end else if ((phase_q == PH_FLAG) || (phase_q == PH_LEAF)) begin
			rpt_status = STS_INCOMPLETE;
		end else if (owed) begin
			rpt_status = STS_TRUNC;
		end else begin
			rpt_status = STS_OK;
		end
	end

	// Memory strobes and result requests.
	always_comb begin
		node_we    = 1'b0;
		node_waddr = nodes_used_q;
		node_wdata = {1'b1, EW'(leaf_sym)};
		node_re    = go_fetch;
		stack_we   = bit_step && (phase_q == PH_FLAG) && !ovf_nodes && !cur_bit && !ovf_stack;
		stack_re   = go_link;
		if (bit_step && (phase_q == PH_LEAF) && leaf_end) begin
			node_we = 1'b1;
		end else if (state_q == S_LINK) begin
			node_we    = 1'b1;
			node_waddr = stack_rdata;
			node_wdata = {1'b0, EW'(nodes_used_q)};
		end

		oreq.sym_valid  = fetch_step && node_rdata[DW-1];
		oreq.symbol     = node_rdata[SYM_BITS-1:0];
		oreq.close      = (bit_step && last_bit && !go_link && !go_fetch) ||
			(fetch_step && close_q);
		oreq.rpt_valid  = report_step;
		oreq.rpt_status = rpt_status;
	end

	// Sequencer and decoder state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			phase_q      <= PH_FLAG;
			expected_q   <= '0;
			decoded_q    <= '0;
			nodes_used_q <= '0;
			level_q      <= '0;
			leaf_cnt_q   <= '0;
			leaf_shift_q <= '0;
			walk_q       <= '0;
			cur_right_q  <= '0;
			root_right_q <= '0;
			next_q       <= '0;
			close_q      <= 1'b0;
			err_q        <= STS_OK;
		end else begin
			if (cfg_valid && cfg_ready) begin
				expected_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= s_tuser ? S_REPORT : S_BIT;
					end
				end
				S_BIT: begin
					if (bit_step) begin
						close_q <= last_bit;
						if (go_link) begin
							state_q <= S_LINK;
						end else if (go_fetch) begin
							state_q <= S_FETCH;
						end else if (last_bit) begin
							state_q <= S_IDLE;
						end
						unique case (phase_q)
							PH_FLAG: begin
								if (ovf_nodes) begin
									err_q   <= STS_OVERFLOW;
									phase_q <= PH_HALT;
								end else if (cur_bit) begin
									phase_q      <= PH_LEAF;
									leaf_cnt_q   <= '0;
									leaf_shift_q <= '0;
								end else if (ovf_stack) begin
									err_q   <= STS_OVERFLOW;
									phase_q <= PH_HALT;
								end else begin
									level_q      <= level_q + SW'(1);
									nodes_used_q <= nodes_used_q + NW'(1);
								end
							end
							PH_LEAF: begin
								leaf_shift_q <= leaf_sym;
								if (leaf_end) begin
									nodes_used_q <= nodes_used_q + NW'(1);
									if (level_q == '0) begin
										phase_q     <= PH_DECODE;
										walk_q      <= '0;
										cur_right_q <= root_right_q;
									end else begin
										level_q <= level_q - SW'(1);
										phase_q <= PH_FLAG;
									end
								end else begin
									leaf_cnt_q <= leaf_cnt_q + LeafCW'(1);
								end
							end
							PH_DECODE: begin
								if (owed && root_leaf) begin
									err_q   <= STS_SINGLE;
									phase_q <= PH_HALT;
								end else if (owed) begin
									next_q <= next_idx;
								end
							end
							PH_HALT: begin
							end
						endcase
					end
				end
				S_LINK: begin
					// The popped node gets the next node as its right child.
					if (stack_rdata == '0) begin
						root_right_q <= nodes_used_q;
					end
					state_q <= close_q ? S_IDLE : S_BIT;
				end
				S_FETCH: begin
					if (fetch_step) begin
						if (node_rdata[DW-1]) begin
							decoded_q   <= decoded_q + 32'd1;
							walk_q      <= '0;
							cur_right_q <= root_right_q;
						end else begin
							walk_q      <= next_q;
							cur_right_q <= node_rdata[NW-1:0];
						end
						state_q <= close_q ? S_IDLE : S_BIT;
					end
				end
				S_REPORT: begin
					if (report_step) begin
						state_q      <= S_IDLE;
						phase_q      <= PH_FLAG;
						decoded_q    <= '0;
						nodes_used_q <= '0;
						level_q      <= '0;
						leaf_cnt_q   <= '0;
						leaf_shift_q <= '0;
						walk_q       <= '0;
						err_q        <= STS_OK;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	hpd_bit_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_acc && !s_tuser),
		.load_byte (s_tdata),
		.advance   (bit_step),
		.cur_bit   (cur_bit),
		.last_bit  (last_bit)
	);

	hpd_ram #(
		.AW (NW),
		.DW (DW)
	) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.re    (node_re),
		.raddr (next_idx),
		.rdata (node_rdata)
	);

	hpd_ram #(
		.AW (SW),
		.DW (NW)
	) u_stack_ram (
		.clk   (clk),
		.we    (stack_we),
		.waddr (level_q),
		.wdata (nodes_used_q),
		.re    (stack_re),
		.raddr (stack_raddr),
		.rdata (stack_rdata)
	);

	hpd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (oreq),
		.sts      (osts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// A latched error and the halted phase always go together.
	a_halt_err: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HALT) == (err_q != STS_OK))
		else $error("halt phase and error latch disagree");

	// A node read for the walk is only outstanding in the decode phase.
	a_fetch_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FETCH) |-> (phase_q == PH_DECODE))
		else $error("node fetch outside decode phase");

	// A status report is always the last result of its beat.
	a_report_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("status report not marked last");

	// The stack level never passes the number of pending nodes a tree can have.
	a_level_max: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= SW'(MAX_LEAVES - 1))
		else $error("pending stack level out of range");

endmodule

>>> tb/sv/hpd_tb_pkg.sv
`timescale 1ns / 1ps
// Input command codes of the preorder-tree Huffman decoder as seen on s_tuser.
// Shared by the stream checker and the testbench top; depends on nothing.
package hpd_tb_pkg;

	typedef enum logic {
		CMD_DATA = 1'b0,
		CMD_END  = 1'b1
	} command_t;

endpackage

>>> tb/sv/hpd_stream_checker.sv
`timescale 1ns / 1ps
// Stream checker for the preorder-tree Huffman decoder: watches the config, input and
// result channels, predicts every result beat and compares it. Uses hpd_pkg, hpd_tb_pkg.
module hpd_stream_checker #(
	parameter int MAX_LEAVES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	input  logic        m_tuser,
	input  logic        m_tlast,
	output int          mismatches,
	output int          outstanding
);
	import hpd_pkg::*;
	import hpd_tb_pkg::*;

	localparam int NODE_LIMIT = 2 * MAX_LEAVES - 1;

	typedef enum logic [1:0] {
		PH_FLAG   = 2'd0,
		PH_LEAF   = 2'd1,
		PH_DECODE = 2'd2,
		PH_HALTED = 2'd3
	} walk_phase_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] symbol;
		status_t    status;
		logic       last;
	} result_t;

	// Shadow of the decoder: tree memory, pending right links and walk state.
	logic [9:0]  node_mem [512];
	logic [8:0]  link_mem [256];
	logic [9:0]  nodes_used;
	logic [8:0]  stack_level;
	walk_phase_t phase;
	logic [3:0]  leaf_left;
	logic [7:0]  leaf_acc;
	logic [8:0]  walk;
	logic [31:0] decoded;
	status_t     fault;
	logic [31:0] symbol_target;

	result_t owed [$];
	int      fail_cnt = 0;

	task automatic clear_decoder();
		foreach (node_mem[k]) node_mem[k] = '0;
		foreach (link_mem[k]) link_mem[k] = '0;
		nodes_used  = '0;
		stack_level = '0;
		phase       = PH_FLAG;
		leaf_left   = '0;
		leaf_acc    = '0;
		walk        = '0;
		decoded     = '0;
		fault       = STS_OK;
	endtask

	task automatic halt_with(input status_t code);
		fault = code;
		phase = PH_HALTED;
	endtask

	// One compressed bit through the tree builder or the tree walker.
	task automatic step_bit(input logic b, output logic hit, output logic [7:0] sym);
		logic [9:0] cur;
		logic [8:0] nxt;
		hit = 1'b0;
		sym = '0;
		case (phase)
			PH_FLAG: begin
				if (nodes_used >= NODE_LIMIT) begin
					halt_with(STS_OVERFLOW);
				end else if (b) begin
					phase     = PH_LEAF;
					leaf_left = 4'd8;
					leaf_acc  = '0;
				end else if (stack_level >= MAX_LEAVES - 1) begin
					halt_with(STS_OVERFLOW);
				end else begin
					node_mem[nodes_used[8:0]] = '0;
					link_mem[stack_level[7:0]] = nodes_used[8:0];
					stack_level++;
					nodes_used++;
				end
			end
			PH_LEAF: begin
				leaf_acc = {leaf_acc[6:0], b};
				if (leaf_left > 0)
					leaf_left--;
				if (leaf_left == 0) begin
					node_mem[nodes_used[8:0]] = {2'b10, leaf_acc};
					nodes_used++;
					if (stack_level == 0) begin
						phase = PH_DECODE;
						walk  = '0;
					end else begin
						// The popped node gets the next node as its right child.
						stack_level--;
						node_mem[link_mem[stack_level[7:0]]] = {1'b0, nodes_used[8:0]};
						phase = PH_FLAG;
					end
				end
			end
			PH_DECODE: begin
				if (decoded < symbol_target) begin
					cur = node_mem[walk];
					if (cur[9]) begin
						halt_with(STS_SINGLE);
					end else begin
						nxt = b ? cur[8:0] : walk + 9'd1;
						if (node_mem[nxt][9]) begin
							hit  = 1'b1;
							sym  = node_mem[nxt][7:0];
							decoded++;
							walk = '0;
						end else begin
							walk = nxt;
						end
					end
				end
			end
			default: ;
		endcase
	endtask

	// Expected results of one accepted input beat.
	task automatic absorb_beat(input logic cmd, input logic [7:0] value);
		result_t    res;
		logic       hit;
		logic [7:0] sym;
		logic [7:0] syms [8];
		int         n;
		n = 0;
		if (cmd == CMD_END) begin
			res.kind   = KIND_REPORT;
			res.symbol = '0;
			res.last   = 1'b1;
			if (fault != STS_OK)
				res.status = fault;
			else if (phase == PH_FLAG || phase == PH_LEAF)
				res.status = STS_INCOMPLETE;
			else if (decoded < symbol_target)
				res.status = STS_TRUNC;
			else
				res.status = STS_OK;
			owed.push_back(res);
			clear_decoder();
		end else begin
			for (int i = 7; i >= 0; i--) begin
				step_bit(value[i], hit, sym);
				if (hit) begin
					syms[n] = sym;
					n++;
				end
			end
			for (int k = 0; k < n; k++) begin
				res.kind   = KIND_SYMBOL;
				res.symbol = syms[k];
				res.status = STS_OK;
				res.last   = (k == n - 1);
				owed.push_back(res);
			end
		end
	endtask

	task automatic compare_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			fail_cnt++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		end
	endtask

	// Compare one result beat against the oldest expectation.
	task automatic check_result();
		result_t want;
		if (owed.size() == 0) begin
			fail_cnt++;
			$display("%0t: result beat with nothing expected, expected none, actual kind %0d symbol %0h status %0d last %0b",
				$time, m_tuser, m_tdata[7:0], m_tdata[10:8], m_tlast);
		end else begin
			want = owed.pop_front();
			compare_field("kind", want.kind, m_tuser);
			compare_field("symbol", want.symbol, m_tdata[7:0]);
			compare_field("status", want.status, m_tdata[10:8]);
			compare_field("last", want.last, m_tlast);
			compare_field("tdata padding", 0, m_tdata[15:11]);
		end
	endtask

	// Channels are sampled at the edge; inputs before results.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_target = '0;
			clear_decoder();
			owed.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				symbol_target = cfg_data;
			if (s_tvalid && s_tready)
				absorb_beat(s_tuser, s_tdata);
			if (m_tvalid && m_tready)
				check_result();
		end
		outstanding <= owed.size();
		mismatches  <= fail_cnt;
	end

endmodule

>>> tb/sv/huffman_preorder_tree_decoder_tb.sv
`timescale 1ns / 1ps
// Testbench top of the preorder-tree Huffman decoder: builds coded streams, drives the
// config and input channels, paces the result channel. Uses hpd_pkg, hpd_tb_pkg, hpd_stream_checker.
module huffman_preorder_tree_decoder_tb;
	import hpd_pkg::*;
	import hpd_tb_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_BEATS = 230;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [31:0]         cfg_data;
	logic                s_tvalid;
	logic                s_tready;
	logic [7:0]          s_tdata;
	logic                s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [TDATA_W-1:0]  m_tdata;
	logic                m_tuser;
	logic                m_tlast;

	int mismatches;
	int outstanding;
	int beats_sent;
	int cycle_count;
	bit steady;
	bit hold_req;

	// Stream under construction, and the code of every leaf of the current tree.
	bit           coded_bits [$];
	logic [255:0] leaf_path [256];
	int           leaf_depth [256];
	int           tree_leaves;

	huffman_preorder_tree_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	hpd_stream_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Result side: random back-pressure, one long hold-off when asked.
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		m_tready  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= steady || ($urandom_range(0, 99) >= 28);
		end
	end

	// One input beat; valid stays high when the next beat follows without a gap.
	task automatic send_beat(input command_t cmd, input logic [7:0] value);
		int gap;
		gap = 0;
		if (!steady)
			while ($urandom_range(0, 99) < 28) gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		beats_sent++;
	endtask

	// Wait until every expected result is out, let the block settle, then write the count.
	task automatic write_symbol_count(input logic [31:0] count);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= count;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic put_bits(input logic [255:0] value, input int count);
		for (int k = count - 1; k >= 0; k--)
			coded_bits.push_back(value[k]);
	endtask

	// Pad the stream to whole bytes with random bits and send it.
	task automatic send_bits();
		logic [7:0] packed_byte;
		packed_byte = '0;
		while (coded_bits.size() % 8 != 0)
			coded_bits.push_back($urandom_range(0, 1));
		while (coded_bits.size() > 0) begin
			for (int k = 0; k < 8; k++)
				packed_byte = {packed_byte[6:0], coded_bits.pop_front()};
			send_beat(CMD_DATA, packed_byte);
		end
	endtask

	// Random tree in preorder with the given number of leaves; records each leaf's code.
	task automatic put_tree(input int leaves);
		logic [255:0] path;
		logic [255:0] right_path [256];
		int           right_depth [256];
		int           depth;
		int           top;
		int           inner;
		bit           done;
		path        = '0;
		depth       = 0;
		top         = 0;
		inner       = 0;
		done        = 1'b0;
		tree_leaves = 0;
		while (!done) begin
			if (inner < leaves - 1 && (top == 0 || $urandom_range(0, 1) == 0)) begin
				coded_bits.push_back(1'b0);
				right_path[top]  = (path << 1) | 256'd1;
				right_depth[top] = depth + 1;
				top++;
				path = path << 1;
				depth++;
				inner++;
			end else begin
				coded_bits.push_back(1'b1);
				put_bits($urandom_range(0, 255), 8);
				leaf_path[tree_leaves]  = path;
				leaf_depth[tree_leaves] = depth;
				tree_leaves++;
				if (top == 0) begin
					done = 1'b1;
				end else begin
					top--;
					path  = right_path[top];
					depth = right_depth[top];
				end
			end
		end
	endtask

	task automatic put_symbols(input int count);
		int pick;
		repeat (count) begin
			pick = $urandom_range(0, tree_leaves - 1);
			put_bits(leaf_path[pick], leaf_depth[pick]);
		end
	endtask

	// One stream closed by end of input: mostly well formed, some cut, junk or noise.
	task automatic random_stream(input int count);
		int flavor;
		int leaves;
		int keep;
		flavor = $urandom_range(0, 99);
		leaves = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(2, 12);
		if (flavor < 12) begin
			repeat ($urandom_range(1, 5)) send_beat(CMD_DATA, $urandom_range(0, 255));
		end else begin
			put_tree(leaves);
			put_symbols(flavor < 22 ? $urandom_range(0, count) : count);
			if (flavor >= 22 && flavor < 32) begin
				keep = $urandom_range(0, coded_bits.size());
				while (coded_bits.size() > keep) void'(coded_bits.pop_back());
			end
			send_bits();
			if (flavor >= 32 && flavor < 42)
				repeat ($urandom_range(1, 3)) send_beat(CMD_DATA, $urandom_range(0, 255));
		end
		send_beat(CMD_END, $urandom_range(0, 255));
	endtask

	// Stimulus and verdict.
	initial begin
		int count;
		int phase_no;
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = CMD_DATA;
		steady     = 1'b0;
		hold_req   = 1'b0;
		beats_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		write_symbol_count(32'd3);
		// Empty input leaves the tree unfinished.
		send_beat(CMD_END, 8'h00);
		// Two leaves carrying the extreme symbols, then three codes.
		put_bits(19'b0_1_00000000_1_11111111, 19);
		put_bits(3'b010, 3);
		send_bits();
		send_beat(CMD_END, 8'hFF);
		// A tree of one leaf, then decode bits while symbols are owed.
		put_bits(9'b1_10100101, 9);
		send_bits();
		send_beat(CMD_END, 8'h00);
		// Input ending inside a leaf symbol.
		send_beat(CMD_DATA, 8'h40);
		send_beat(CMD_END, 8'h00);

		write_symbol_count(32'd0);
		// Nothing owed: decode bits are ignored, with one leaf or two.
		put_bits(19'b0_1_00000000_1_11111111, 19);
		send_bits();
		send_beat(CMD_DATA, 8'hFF);
		send_beat(CMD_END, 8'h00);
		put_bits(9'b1_11111111, 9);
		send_bits();
		send_beat(CMD_END, 8'hFF);

		write_symbol_count(32'hFFFF_FFFF);
		// Every bit a symbol: eight results per byte, never enough of them.
		put_bits(19'b0_1_00000000_1_11111111, 19);
		send_bits();
		send_beat(CMD_DATA, 8'h00);
		send_beat(CMD_DATA, 8'hFF);
		send_beat(CMD_DATA, 8'h55);
		send_beat(CMD_END, 8'h00);

		// Random phases; one of them runs without idling on either side.
		phase_no = 0;
		count    = beats_sent + RANDOM_BEATS;
		while (beats_sent < count) begin
			steady <= (phase_no == 2);
			write_symbol_count(($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) :
				$urandom_range(0, 12));
			repeat ($urandom_range(2, 4))
				random_stream(i_checker_count());
			phase_no++;
		end
		steady <= 1'b0;

		// Long hold-off on the result side while a symbol-dense stream keeps coming.
		write_symbol_count(32'd200);
		hold_req <= 1'b1;
		put_tree(2);
		put_symbols(200);
		send_bits();
		send_beat(CMD_END, 8'h00);

		// Too many pending nodes: 256 left branches in a row.
		repeat (32) send_beat(CMD_DATA, 8'h00);
		send_beat(CMD_DATA, $urandom_range(0, 255));
		send_beat(CMD_END, 8'h00);

		// Node store full before the tree closes.
		put_bits(3'b000, 3);
		repeat (254) begin
			put_bits(2'b01, 2);
			put_bits($urandom_range(0, 255), 8);
		end
		send_bits();
		send_beat(CMD_DATA, $urandom_range(0, 255));
		send_beat(CMD_END, 8'h00);

		// Largest tree, then a few symbols through it.
		write_symbol_count(32'd24);
		put_tree(256);
		put_symbols(24);
		send_bits();
		send_beat(CMD_END, 8'hFF);

		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Symbol count of the current phase, as last written on the config channel.
	logic [31:0] written_count;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			written_count <= '0;
		else if (cfg_valid && cfg_ready)
			written_count <= cfg_data;
	end

	function automatic int i_checker_count();
		return int'(written_count);
	endfunction

endmodule
